/* src/multilevel_priority_ready_queue_top_assert.svh */
// Assertion macros for the ready queue top level.
`ifndef MULTILEVEL_PRIORITY_READY_QUEUE_TOP_ASSERT_SVH
`define MULTILEVEL_PRIORITY_READY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MLPRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MLPRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mlprq_pkg.sv */
// Shared constants, codes and types of the ready queue.
package mlprq_pkg;

    localparam int PROC_SLOTS = 64;
    localparam int LEVELS     = 8;
    localparam int NFIFO      = 2 * LEVELS;
    localparam int FIFO_W     = $clog2(NFIFO);
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PTR_W      = $clog2(PROC_SLOTS);
    localparam int CNT_W      = $clog2(PROC_SLOTS + 1);
    localparam int ENT_DEPTH  = NFIFO * PROC_SLOTS;
    localparam int ENT_AW     = $clog2(ENT_DEPTH);
    localparam int TOT_W      = $clog2(ENT_DEPTH + 1);
    localparam int ID_W       = 6;
    localparam int PRIO_W     = 3;
    localparam int MAXP_W     = 4;
    localparam logic [MAXP_W-1:0] MAX_PRIO_RST = 4'd4;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_EMPTY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        FROM_CREATED = 2'd0,
        FROM_BLOCKED = 2'd1,
        FROM_RUNNING = 2'd2,
        FROM_OTHER   = 2'd3
    } origin_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Per-FIFO descriptor held in the descriptor memory.
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } desc_t;

endpackage

/* src/mlprq_entry_ram.sv */
// Process id store: one region of slots per FIFO, registered read.
module mlprq_entry_ram (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [mlprq_pkg::ENT_AW-1:0]     wr_addr,
    input  logic [mlprq_pkg::ID_W-1:0]       wr_data,
    input  logic                             rd_en,
    input  logic [mlprq_pkg::ENT_AW-1:0]     rd_addr,
    output logic [mlprq_pkg::ID_W-1:0]       rd_data
);

    logic [mlprq_pkg::ID_W-1:0] mem [mlprq_pkg::ENT_DEPTH];
    logic [mlprq_pkg::ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/mlprq_desc_ram.sv */
// FIFO descriptor memory (head, tail, fill) with per-entry valid bits.
module mlprq_desc_ram (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             rd_en,
    input  logic [mlprq_pkg::FIFO_W-1:0]     rd_addr,
    output mlprq_pkg::desc_t                 rd_data,
    input  logic                             wr_en,
    input  logic [mlprq_pkg::FIFO_W-1:0]     wr_addr,
    input  mlprq_pkg::desc_t                 wr_data
);

    mlprq_pkg::desc_t                  mem [mlprq_pkg::NFIFO];
    mlprq_pkg::desc_t                  rd_q_reg;
    logic [mlprq_pkg::NFIFO-1:0]       vld_reg;
    logic                              rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // A never-written descriptor reads as all zero.
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

/* src/mlprq_level_pick.sv */
// Highest non-empty level among the FIFOs of one bank.
module mlprq_level_pick (
    input  logic [mlprq_pkg::LEVELS-1:0]     req,
    output logic                             found,
    output logic [mlprq_pkg::LVL_W-1:0]      level
);

    always_comb
    begin
        found = 1'b0;
        level = '0;
        // Ascending scan: the last hit is the highest level.
        for (int i = 0; i < mlprq_pkg::LEVELS; i++)
        begin
            if (req[i])
            begin
                found = 1'b1;
                level = mlprq_pkg::LVL_W'(i);
            end
        end
    end

endmodule

/* src/multilevel_priority_ready_queue_top.sv */
// Ready queue top level: command sequencer over the descriptor and id memories.
//
// Commands are taken while busy is low. An add reads the descriptor memory, then
// writes the id and the updated descriptor; a get that finds a process reads the
// descriptor memory, then reads the id memory while the descriptor is written back.
// An ignored add, a rejected priority, a get on an empty queue, an empty query and
// the unused code touch no memory. Every command gives exactly one result, shown on
// granted, granted_id, all_empty and status for the single cycle in which done is
// high, in the cycle after the command's last cycle; the receiver cannot stall it,
// and the next command may already be taken in that cycle. max_prio is to be
// written with max_prio_we only while no command is in flight; the block does not
// enforce this. It resets to 4. No clearing pass follows reset.
module multilevel_priority_ready_queue_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       cmd,
    input  logic [mlprq_pkg::ID_W-1:0]       proc_id,
    input  logic [mlprq_pkg::PRIO_W-1:0]     priority_req,
    input  logic [1:0]                       came_from,
    input  logic                             prio_was_reset,
    input  logic                             max_prio_we,
    input  logic [mlprq_pkg::MAXP_W-1:0]     max_prio,
    output logic                             done,
    output logic                             granted,
    output logic [mlprq_pkg::ID_W-1:0]       granted_id,
    output logic                             all_empty,
    output logic [1:0]                       status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DESC,
        S_DATA
    } state_t;

    state_t                              state_reg, state_next;
    logic                                op_get_reg, op_get_next;
    logic [mlprq_pkg::FIFO_W-1:0]        fifo_reg, fifo_next;
    logic                                tgt_bank_reg, tgt_bank_next;
    logic [mlprq_pkg::ID_W-1:0]          id_reg, id_next;
    logic                                bank_reg, bank_next;
    logic [mlprq_pkg::TOT_W-1:0]         act_tot_reg, act_tot_next;
    logic [mlprq_pkg::TOT_W-1:0]         exp_tot_reg, exp_tot_next;
    logic [mlprq_pkg::NFIFO-1:0]         ne_reg, ne_next;
    logic [mlprq_pkg::MAXP_W-1:0]        max_prio_reg, max_prio_next;
    logic                                done_reg, done_next;
    logic                                granted_reg, granted_next;
    logic [mlprq_pkg::ID_W-1:0]          gid_reg, gid_next;
    logic                                all_empty_reg, all_empty_next;
    mlprq_pkg::status_t                  status_reg, status_next;

    logic                                accept;
    logic                                swap;
    logic                                eff_bank;
    logic                                add_bank;
    logic                                in_range;
    logic [mlprq_pkg::FIFO_W-1:0]        add_fifo;
    logic [mlprq_pkg::FIFO_W-1:0]        get_fifo;
    logic [mlprq_pkg::LEVELS-1:0]        pick_req;
    logic                                pick_found;
    logic [mlprq_pkg::LVL_W-1:0]         pick_level;
    logic                                both_empty;

    logic                                desc_rd_en;
    logic [mlprq_pkg::FIFO_W-1:0]        desc_rd_addr;
    mlprq_pkg::desc_t                    desc_rd;
    logic                                desc_wr_en;
    mlprq_pkg::desc_t                    desc_wr;

    logic                                ent_wr_en;
    logic                                ent_rd_en;
    logic [mlprq_pkg::ENT_AW-1:0]        ent_wr_addr;
    logic [mlprq_pkg::ENT_AW-1:0]        ent_rd_addr;
    logic [mlprq_pkg::ID_W-1:0]          ent_rd;

    function automatic logic [mlprq_pkg::PTR_W-1:0] next_ptr(
        input logic [mlprq_pkg::PTR_W-1:0] p
    );
        return (p == mlprq_pkg::PTR_W'(mlprq_pkg::PROC_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [mlprq_pkg::ENT_AW-1:0] ent_addr(
        input logic [mlprq_pkg::FIFO_W-1:0] f,
        input logic [mlprq_pkg::PTR_W-1:0]  p
    );
        return mlprq_pkg::ENT_AW'(32'(f) * mlprq_pkg::PROC_SLOTS + 32'(p));
    endfunction

    mlprq_desc_ram u_desc (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (desc_rd_en),
        .rd_addr (desc_rd_addr),
        .rd_data (desc_rd),
        .wr_en   (desc_wr_en),
        .wr_addr (fifo_reg),
        .wr_data (desc_wr)
    );

    mlprq_entry_ram u_entry (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (id_reg),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd)
    );

    mlprq_level_pick u_pick (
        .req   (pick_req),
        .found (pick_found),
        .level (pick_level)
    );

    assign accept     = start && (state_reg == S_IDLE);
    assign swap       = (act_tot_reg == '0);
    assign both_empty = (act_tot_reg == '0) && (exp_tot_reg == '0);
    assign eff_bank   = bank_reg ^ swap;
    assign in_range   = (32'(priority_req) < 32'(max_prio_reg))
                        && (32'(priority_req) < mlprq_pkg::LEVELS);
    assign add_bank   = bank_reg ^ ((came_from == mlprq_pkg::FROM_RUNNING) && prio_was_reset);
    assign add_fifo   = mlprq_pkg::FIFO_W'(32'(add_bank) * mlprq_pkg::LEVELS
                                           + 32'(priority_req));
    assign get_fifo   = mlprq_pkg::FIFO_W'(32'(eff_bank) * mlprq_pkg::LEVELS
                                           + 32'(pick_level));

    always_comb
    begin
        for (int i = 0; i < mlprq_pkg::LEVELS; i++)
        begin
            pick_req[i] = ne_reg[mlprq_pkg::FIFO_W'(32'(eff_bank) * mlprq_pkg::LEVELS + i)];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op_get_next    = op_get_reg;
        fifo_next      = fifo_reg;
        tgt_bank_next  = tgt_bank_reg;
        id_next        = id_reg;
        bank_next      = bank_reg;
        act_tot_next   = act_tot_reg;
        exp_tot_next   = exp_tot_reg;
        ne_next        = ne_reg;
        max_prio_next  = max_prio_we ? max_prio : max_prio_reg;
        done_next      = 1'b0;
        granted_next   = 1'b0;
        gid_next       = '0;
        all_empty_next = both_empty;
        status_next    = mlprq_pkg::ST_OK;
        desc_rd_en     = 1'b0;
        desc_rd_addr   = add_fifo;
        desc_wr_en     = 1'b0;
        desc_wr        = desc_rd;
        ent_wr_en      = 1'b0;
        ent_rd_en      = 1'b0;
        ent_wr_addr    = ent_addr(fifo_reg, desc_rd.tail);
        ent_rd_addr    = ent_addr(fifo_reg, desc_rd.head);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mlprq_pkg::cmd_t'(cmd))
                        mlprq_pkg::CMD_ADD:
                        begin
                            if (came_from == mlprq_pkg::FROM_OTHER)
                            begin
                                done_next = 1'b1;
                            end
                            else if (!in_range)
                            begin
                                done_next   = 1'b1;
                                status_next = mlprq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                desc_rd_en    = 1'b1;
                                desc_rd_addr  = add_fifo;
                                fifo_next     = add_fifo;
                                tgt_bank_next = add_bank;
                                id_next       = proc_id;
                                op_get_next   = 1'b0;
                                state_next    = S_DESC;
                            end
                        end
                        mlprq_pkg::CMD_GET:
                        begin
                            if (swap)
                            begin
                                bank_next    = ~bank_reg;
                                act_tot_next = exp_tot_reg;
                                exp_tot_next = act_tot_reg;
                            end
                            if (pick_found)
                            begin
                                desc_rd_en   = 1'b1;
                                desc_rd_addr = get_fifo;
                                fifo_next    = get_fifo;
                                op_get_next  = 1'b1;
                                state_next   = S_DESC;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        mlprq_pkg::CMD_EMPTY:
                        begin
                            // Swapping leaves the sum, so all_empty is unchanged.
                            if (swap)
                            begin
                                bank_next    = ~bank_reg;
                                act_tot_next = exp_tot_reg;
                                exp_tot_next = act_tot_reg;
                            end
                            done_next = 1'b1;
                        end
                        mlprq_pkg::CMD_NOP:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DESC:
            begin
                if (op_get_reg)
                begin
                    ent_rd_en         = 1'b1;
                    desc_wr_en        = 1'b1;
                    desc_wr.head      = next_ptr(desc_rd.head);
                    desc_wr.count     = desc_rd.count - 1'b1;
                    ne_next[fifo_reg] = (desc_rd.count != mlprq_pkg::CNT_W'(1));
                    if (act_tot_reg != '0)
                    begin
                        act_tot_next = act_tot_reg - 1'b1;
                    end
                    state_next = S_DATA;
                end
                else if (desc_rd.count >= mlprq_pkg::CNT_W'(mlprq_pkg::PROC_SLOTS))
                begin
                    done_next   = 1'b1;
                    status_next = mlprq_pkg::ST_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ent_wr_en         = 1'b1;
                    desc_wr_en        = 1'b1;
                    desc_wr.tail      = next_ptr(desc_rd.tail);
                    desc_wr.count     = desc_rd.count + 1'b1;
                    ne_next[fifo_reg] = 1'b1;
                    if (tgt_bank_reg == bank_reg)
                    begin
                        act_tot_next = act_tot_reg + 1'b1;
                    end
                    else
                    begin
                        exp_tot_next = exp_tot_reg + 1'b1;
                    end
                    done_next      = 1'b1;
                    all_empty_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_DATA:
            begin
                done_next    = 1'b1;
                granted_next = 1'b1;
                gid_next     = ent_rd;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_get_reg    <= 1'b0;
            fifo_reg      <= '0;
            tgt_bank_reg  <= 1'b0;
            id_reg        <= '0;
            bank_reg      <= 1'b0;
            act_tot_reg   <= '0;
            exp_tot_reg   <= '0;
            ne_reg        <= '0;
            max_prio_reg  <= mlprq_pkg::MAX_PRIO_RST;
            done_reg      <= 1'b0;
            granted_reg   <= 1'b0;
            gid_reg       <= '0;
            all_empty_reg <= 1'b1;
            status_reg    <= mlprq_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            op_get_reg    <= op_get_next;
            fifo_reg      <= fifo_next;
            tgt_bank_reg  <= tgt_bank_next;
            id_reg        <= id_next;
            bank_reg      <= bank_next;
            act_tot_reg   <= act_tot_next;
            exp_tot_reg   <= exp_tot_next;
            ne_reg        <= ne_next;
            max_prio_reg  <= max_prio_next;
            done_reg      <= done_next;
            granted_reg   <= granted_next;
            gid_reg       <= gid_next;
            all_empty_reg <= all_empty_next;
            status_reg    <= status_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign granted    = granted_reg;
    assign granted_id = gid_reg;
    assign all_empty  = all_empty_reg;
    assign status     = status_reg;

`include "multilevel_priority_ready_queue_top_assert.svh"

    `MLPRQ_ASSERT_NOW(a_done_in_idle, done_reg, state_reg == S_IDLE, "result beat while busy")
    `MLPRQ_ASSERT_NOW(a_grant_ok, done_reg && granted_reg, status_reg == mlprq_pkg::ST_OK, "grant with error status")
    `MLPRQ_ASSERT_NOW(a_pop_nonempty, (state_reg == S_DESC) && op_get_reg, desc_rd.count != '0, "pop from empty FIFO")
    `MLPRQ_ASSERT_NEXT(a_get_to_data, (state_reg == S_DESC) && op_get_reg, (state_reg == S_DATA) && !done_reg, "get skipped data read")
    `MLPRQ_ASSERT_NOW(a_total_bound, 1'b1, (32'(act_tot_reg) + 32'(exp_tot_reg)) <= mlprq_pkg::ENT_DEPTH, "queue totals overflow")

endmodule

/* test/multilevel_priority_ready_queue_top_test.sv */
// Self-checking testbench for the two-bank multilevel priority ready queue.
module multilevel_priority_ready_queue_top_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PEND_DEPTH  = 16;

    typedef struct packed {
        logic                          granted;
        logic [mlprq_pkg::ID_W-1:0]    id;
        logic                          all_empty;
        logic [1:0]                    status;
    } outcome_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      cmd;
    logic [mlprq_pkg::ID_W-1:0]      proc_id;
    logic [mlprq_pkg::PRIO_W-1:0]    priority_req;
    logic [1:0]                      came_from;
    logic                            prio_was_reset;
    logic                            max_prio_we;
    logic [mlprq_pkg::MAXP_W-1:0]    max_prio;
    logic                            done;
    logic                            granted;
    logic [mlprq_pkg::ID_W-1:0]      granted_id;
    logic                            all_empty;
    logic [1:0]                      status;

    // Predicted contents of the queue.
    bit [mlprq_pkg::ID_W-1:0]  slot_ids [mlprq_pkg::NFIFO][mlprq_pkg::PROC_SLOTS];
    bit [mlprq_pkg::PTR_W-1:0] fifo_head [mlprq_pkg::NFIFO];
    bit [mlprq_pkg::PTR_W-1:0] fifo_tail [mlprq_pkg::NFIFO];
    int                        fifo_fill [mlprq_pkg::NFIFO];
    bit                        live_bank;
    int                        live_total;
    int                        spare_total;
    int                        level_limit;

    // Expected results in order of acceptance.
    outcome_t pend_buf [PEND_DEPTH];
    int       pend_wr;
    int       pend_rd;
    int       n_err;
    int       cycles = 0;
    int       burst_left;

    multilevel_priority_ready_queue_top uut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void pend_put(input outcome_t o);
        pend_buf[pend_wr % PEND_DEPTH] = o;
        pend_wr++;
    endfunction

    function automatic outcome_t pend_take();
        outcome_t o;
        o = pend_buf[pend_rd % PEND_DEPTH];
        pend_rd++;
        return o;
    endfunction

    function automatic void swap_if_drained();
        int t;
        if (live_total == 0)
        begin
            live_bank   = ~live_bank;
            t           = live_total;
            live_total  = spare_total;
            spare_total = t;
        end
    endfunction

    function automatic outcome_t ready_queue_step(mlprq_pkg::cmd_t c,
                                                  logic [mlprq_pkg::ID_W-1:0] id,
                                                  logic [mlprq_pkg::PRIO_W-1:0] pr,
                                                  mlprq_pkg::origin_t from,
                                                  logic rs);
        outcome_t o;
        bit       b;
        int       f;
        int       lv;
        o = '0;
        if (c == mlprq_pkg::CMD_ADD && from != mlprq_pkg::FROM_OTHER)
        begin
            if (pr >= level_limit || pr >= mlprq_pkg::LEVELS)
                o.status = mlprq_pkg::ST_RANGE;
            else
            begin
                b = live_bank;
                if (from == mlprq_pkg::FROM_RUNNING && rs)
                    b = ~b;
                f = b * mlprq_pkg::LEVELS + pr;
                if (fifo_fill[f] >= mlprq_pkg::PROC_SLOTS)
                    o.status = mlprq_pkg::ST_FULL;
                else
                begin
                    slot_ids[f][fifo_tail[f]] = id;
                    fifo_tail[f]++;
                    fifo_fill[f]++;
                    if (b == live_bank)
                        live_total++;
                    else
                        spare_total++;
                end
            end
        end
        else if (c == mlprq_pkg::CMD_GET)
        begin
            swap_if_drained();
            // scan every level, including any above the current limit
            for (lv = mlprq_pkg::LEVELS - 1; lv >= 0 && !o.granted; lv--)
            begin
                f = live_bank * mlprq_pkg::LEVELS + lv;
                if (fifo_fill[f] != 0)
                begin
                    o.id = slot_ids[f][fifo_head[f]];
                    fifo_head[f]++;
                    fifo_fill[f]--;
                    if (live_total != 0)
                        live_total--;
                    o.granted = 1'b1;
                end
            end
        end
        else if (c == mlprq_pkg::CMD_EMPTY)
            swap_if_drained();
        o.all_empty = (live_total == 0 && spare_total == 0);
        return o;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            n_err++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pend_wr == pend_rd)
            begin
                n_err++;
                $display("%0t: unexpected result, expected none, got granted=%0b id=%0d",
                         $time, granted, granted_id);
            end
            else
            begin
                want = pend_take();
                check_field("granted", 8'(want.granted), 8'(granted));
                check_field("granted_id", 8'(want.id), 8'(granted_id));
                check_field("all_empty", 8'(want.all_empty), 8'(all_empty));
                check_field("status", 8'(want.status), 8'(status));
            end
        end
    end

    // Send one command beat, then idle the sender when its burst runs out.
    task automatic send_cmd(input mlprq_pkg::cmd_t c, input int id, input int pr,
                            input mlprq_pkg::origin_t from, input int rs);
        start          <= 1'b1;
        cmd            <= c;
        proc_id        <= mlprq_pkg::ID_W'(id);
        priority_req   <= mlprq_pkg::PRIO_W'(pr);
        came_from      <= from;
        prio_was_reset <= (rs != 0);
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pend_put(ready_queue_step(c, mlprq_pkg::ID_W'(id), mlprq_pkg::PRIO_W'(pr), from,
                                  rs != 0));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_results_done();
        start <= 1'b0;
        while (pend_wr != pend_rd)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_prio_limit(input int v);
        wait_results_done();
        max_prio_we <= 1'b1;
        max_prio    <= mlprq_pkg::MAXP_W'(v);
        @(posedge clk);
        max_prio_we <= 1'b0;
        level_limit = v;
    endtask

    task automatic send_random(input int add_pct);
        int              r;
        mlprq_pkg::cmd_t c;
        int              pr;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            c = mlprq_pkg::CMD_ADD;
        else if (r < add_pct + (100 - add_pct) * 7 / 10)
            c = mlprq_pkg::CMD_GET;
        else if (r < 95)
            c = mlprq_pkg::CMD_EMPTY;
        else
            c = mlprq_pkg::CMD_NOP;
        // keep most priorities inside the current limit so the queues fill
        pr = ($urandom_range(0, 4) != 0) ? $urandom_range(0, level_limit - 1)
                                         : $urandom_range(0, 7);
        send_cmd(c, $urandom_range(0, 63), pr,
                 mlprq_pkg::origin_t'($urandom_range(0, 3)), $urandom_range(0, 1));
    endtask

    task automatic test_directed_basics();
        send_cmd(mlprq_pkg::CMD_EMPTY, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 63, 7, mlprq_pkg::FROM_OTHER, 1);     // nothing queued
        send_cmd(mlprq_pkg::CMD_ADD, 63, 0, mlprq_pkg::FROM_CREATED, 0);
        // reset mark only counts when preempted
        send_cmd(mlprq_pkg::CMD_ADD, 0, 3, mlprq_pkg::FROM_BLOCKED, 1);
        send_cmd(mlprq_pkg::CMD_ADD, 42, 3, mlprq_pkg::FROM_RUNNING, 0);
        send_cmd(mlprq_pkg::CMD_ADD, 21, 2, mlprq_pkg::FROM_RUNNING, 1);   // goes to expired
        send_cmd(mlprq_pkg::CMD_ADD, 5, 1, mlprq_pkg::FROM_OTHER, 0);      // ignored origin
        send_cmd(mlprq_pkg::CMD_ADD, 6, 4, mlprq_pkg::FROM_CREATED, 0);    // at the reset limit
        send_cmd(mlprq_pkg::CMD_ADD, 7, 7, mlprq_pkg::FROM_RUNNING, 1);
        send_cmd(mlprq_pkg::CMD_NOP, 63, 7, mlprq_pkg::FROM_OTHER, 1);
        send_cmd(mlprq_pkg::CMD_EMPTY, 9, 1, mlprq_pkg::FROM_BLOCKED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        // active drained: banks swap
        send_cmd(mlprq_pkg::CMD_EMPTY, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_ADD, 1, 0, mlprq_pkg::FROM_RUNNING, 1);
        // swap, then serve from expired
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_NOP, 0, 0, mlprq_pkg::FROM_CREATED, 0);
    endtask

    task automatic test_prio_limit_extremes();
        set_prio_limit(8);
        send_cmd(mlprq_pkg::CMD_ADD, 7, 7, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_ADD, 8, 0, mlprq_pkg::FROM_BLOCKED, 0);
        set_prio_limit(1);
        send_cmd(mlprq_pkg::CMD_ADD, 10, 1, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_ADD, 9, 0, mlprq_pkg::FROM_BLOCKED, 0);
        // level 7 is above the limit now but must still be served
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_GET, 0, 0, mlprq_pkg::FROM_CREATED, 0);
        send_cmd(mlprq_pkg::CMD_EMPTY, 0, 0, mlprq_pkg::FROM_CREATED, 0);
    endtask

    task automatic test_fifo_full();
        int                 lv;
        bit                 to_spare;
        int                 k;
        mlprq_pkg::origin_t from;
        set_prio_limit(8);
        lv       = $urandom_range(0, 7);
        to_spare = $urandom_range(0, 1);
        for (k = 0; k < mlprq_pkg::PROC_SLOTS + 3; k++)
        begin
            from = to_spare ? mlprq_pkg::FROM_RUNNING
                            : mlprq_pkg::origin_t'($urandom_range(0, 2));
            send_cmd(mlprq_pkg::CMD_ADD, $urandom_range(0, 63), lv, from, int'(to_spare));
        end
        for (k = 0; k < mlprq_pkg::PROC_SLOTS + 3; k++)
            send_cmd(mlprq_pkg::CMD_GET, $urandom_range(0, 63), $urandom_range(0, 7),
                     mlprq_pkg::origin_t'($urandom_range(0, 3)), $urandom_range(0, 1));
    endtask

    task automatic test_random_traffic();
        int limits [6] = '{8, 1, 5, 2, 8, 3};
        int ph;
        int k;
        limits[2] = $urandom_range(1, 8);
        for (ph = 0; ph < 6; ph++)
        begin
            set_prio_limit(limits[ph]);
            for (k = 0; k < 250; k++)
            begin
                send_random((ph % 2 == 0) ? 65 : 40);
                if ($urandom_range(0, 199) == 0)
                    wait_results_done();
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        cmd            <= mlprq_pkg::CMD_NOP;
        proc_id        <= '0;
        priority_req   <= '0;
        came_from      <= mlprq_pkg::FROM_CREATED;
        prio_was_reset <= 1'b0;
        max_prio_we    <= 1'b0;
        max_prio       <= mlprq_pkg::MAX_PRIO_RST;
        level_limit    = int'(mlprq_pkg::MAX_PRIO_RST);
        live_bank      = 1'b0;
        live_total     = 0;
        spare_total    = 0;
        pend_wr        = 0;
        pend_rd        = 0;
        n_err          = 0;
        burst_left     = 5;
        foreach (fifo_fill[i])
        begin
            fifo_fill[i] = 0;
            fifo_head[i] = '0;
            fifo_tail[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_prio_limit_extremes();
        test_fifo_full();
        test_random_traffic();

        wait_results_done();
        repeat (10) @(posedge clk);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
